### hdl/gbmc_pkg.sv
// Shared constants, codes and the GF(2) matrix-vector product of the byte cipher.
package gbmc_pkg;

   localparam int MatrixRows = 8;
   localparam int HeaderBytes = 9;

   // Header layout; the data byte of a run follows at DATA_POS
   localparam logic [3:0] HDR_LEN = 4'(HeaderBytes);
   localparam logic [3:0] POS_MAGIC0 = 4'd0;
   localparam logic [3:0] POS_MAGIC1 = 4'd1;
   localparam logic [3:0] POS_FLAGS = 4'd2;
   localparam logic [3:0] POS_IV = 4'd3;
   localparam logic [3:0] POS_IDX0 = 4'd4;
   localparam logic [3:0] POS_IDX1 = 4'd5;
   localparam logic [3:0] POS_IDX2 = 4'd6;
   localparam logic [3:0] POS_IDX3 = 4'd7;
   localparam logic [3:0] POS_VERSION = 4'd8;
   localparam logic [3:0] DATA_POS = 4'(HeaderBytes);

   localparam logic [7:0] MAGIC0 = 8'h48;
   localparam logic [7:0] MAGIC1 = 8'h43;
   localparam logic [7:0] VERSION_BYTE = 8'h01;
   localparam logic [7:0] TABLE_FLAG = 8'h80;
   localparam logic [7:0] MODE_CBC_FLAG = 8'h01;

   // Status codes
   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_BAD_MODE = 2'd2;

   // Register indexes
   localparam logic [2:0] CSR_DIRECTION = 3'd0;
   localparam logic [2:0] CSR_CHAIN_MODE = 3'd1;
   localparam logic [2:0] CSR_IV_SOURCE = 3'd2;
   localparam logic [2:0] CSR_IV_TABLE_INDEX = 3'd3;
   localparam logic [2:0] CSR_IV_VALUE = 3'd4;
   localparam logic [2:0] CSR_ENCRYPT_MATRIX = 3'd5;
   localparam logic [2:0] CSR_DECRYPT_MATRIX = 3'd6;

   // Result bit 7-i is the parity of row i AND v; row 0 sits in the top byte
   function automatic logic [7:0] gf2_mul(input logic [63:0] m, input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < MatrixRows; i++) begin
         r[MatrixRows - 1 - i] = ^(m[63 - 8 * i -: 8] & v);
      end
      return r;
   endfunction

endpackage

### hdl/gbmc_req_if.sv
// Request channel: one byte of a message with its start marker.
interface gbmc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_message;

   modport source(output valid, output data_byte, output start_of_message, input ready);
   modport sink(input valid, input data_byte, input start_of_message, output ready);
endinterface

### hdl/gbmc_rsp_if.sv
// Response channel: one output byte with header flag, status and end-of-run marker.
interface gbmc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_header;
   logic [1:0] status;
   logic       last_of_run;

   modport source(output valid, output out_byte, output is_header, output status,
                  output last_of_run, input ready);
   modport sink(input valid, input out_byte, input is_header, input status,
                input last_of_run, output ready);
endinterface

### hdl/gf2_byte_matrix_cipher_cbc_top.sv
// Byte matrix cipher over GF(2) with ECB/CBC chaining and message header handling.
// Each request passes through the input register and then the output slot.
// Throughput: one byte per cycle while rsp ready holds; a message start in encrypt
// direction makes a run of ten results (nine header bytes and the ciphertext byte),
// which the single output slot drains at one result per ready cycle before the next byte.
// Reset (synchronous, active high) clears config registers, chaining state and all valids.
module gf2_byte_matrix_cipher_cbc_top (
   input  logic        clock,
   input  logic        reset,
   gbmc_req_if.sink    req_ch,
   gbmc_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic        direction_ff;
   logic        chain_mode_ff;
   logic        iv_source_ff;
   logic [31:0] iv_table_index_ff;
   logic [7:0]  iv_value_ff;
   logic [63:0] encrypt_matrix_ff;
   logic [63:0] decrypt_matrix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff      <= 1'b0;
         chain_mode_ff     <= 1'b0;
         iv_source_ff      <= 1'b0;
         iv_table_index_ff <= '0;
         iv_value_ff       <= '0;
         encrypt_matrix_ff <= '0;
         decrypt_matrix_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            gbmc_pkg::CSR_DIRECTION:      direction_ff      <= csr_wdata[0];
            gbmc_pkg::CSR_CHAIN_MODE:     chain_mode_ff     <= csr_wdata[0];
            gbmc_pkg::CSR_IV_SOURCE:      iv_source_ff      <= csr_wdata[0];
            gbmc_pkg::CSR_IV_TABLE_INDEX: iv_table_index_ff <= csr_wdata[31:0];
            gbmc_pkg::CSR_IV_VALUE:       iv_value_ff       <= csr_wdata[7:0];
            gbmc_pkg::CSR_ENCRYPT_MATRIX: encrypt_matrix_ff <= csr_wdata;
            gbmc_pkg::CSR_DECRYPT_MATRIX: decrypt_matrix_ff <= csr_wdata;
            default: ;  // index 7 is not a register: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // Input register: holds one accepted transaction until the output slot can take
   // its results. Ready stays high while that transaction moves on in the same cycle.
   // ---------------------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_som_ff;
   logic       in_advance;
   logic       req_take;

   assign req_ch.ready = !in_valid_ff || in_advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (in_advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_ch.data_byte;
         in_som_ff  <= req_ch.start_of_message;
      end
   end

   // ---------------------------------------------------------------------------------
   // Message state
   // ---------------------------------------------------------------------------------
   logic [7:0] chain_ff, chain_in;
   logic [3:0] hdr_cnt_ff, hdr_cnt_in;
   logic       mode_ff, mode_in;
   logic       tflag_ff, tflag_in;
   logic       dropped_ff, dropped_in;

   // Output slot: one run of results, walked by a position counter.
   // A header run starts at the first magic byte, a single result starts at DATA_POS.
   logic        slot_valid_ff;
   logic [3:0]  slot_pos_ff;
   logic [7:0]  slot_flags_ff;
   logic [7:0]  slot_iv_ff;
   logic [31:0] slot_idx_ff;
   logic [7:0]  slot_byte_ff;
   logic [1:0]  slot_status_ff;
   logic        slot_done;

   // Results of processing the byte in the input register
   logic        res_valid;
   logic        res_header;
   logic [7:0]  res_flags;
   logic [7:0]  res_iv;
   logic [31:0] res_idx;
   logic [7:0]  res_byte;
   logic [1:0]  res_status;

   // Intermediate values
   logic [3:0] hc0;
   logic [7:0] chain0;
   logic       drop0;
   logic [7:0] enc_chain;
   logic       enc_mode;
   logic [7:0] enc_byte;
   logic [7:0] dec_byte;
   logic [6:0] hdr_mode;

   always_comb begin
      // Message start restarts header and chaining
      hc0    = in_som_ff ? '0 : hdr_cnt_ff;
      drop0  = in_som_ff ? 1'b0 : dropped_ff;
      chain0 = in_som_ff ? '0 : chain_ff;

      chain_in   = chain0;
      hdr_cnt_in = hc0;
      mode_in    = mode_ff;
      tflag_in   = tflag_ff;
      dropped_in = drop0;

      res_valid  = 1'b0;
      res_header = 1'b0;
      res_flags  = '0;
      res_iv     = '0;
      res_idx    = '0;
      res_byte   = '0;
      res_status = gbmc_pkg::STATUS_OK;

      enc_chain = chain0;
      enc_mode  = mode_ff;
      enc_byte  = '0;
      dec_byte  = gbmc_pkg::gf2_mul(decrypt_matrix_ff, in_data_ff);
      hdr_mode  = in_data_ff[6:0];

      if (!direction_ff) begin
         // Encrypt: latch the config and emit the header ahead of the first byte
         if (hc0 < gbmc_pkg::HDR_LEN) begin
            enc_mode   = chain_mode_ff;
            enc_chain  = iv_value_ff;
            mode_in    = chain_mode_ff;
            tflag_in   = iv_source_ff;
            hdr_cnt_in = gbmc_pkg::HDR_LEN;
            dropped_in = 1'b0;
            res_header = 1'b1;
            if (chain_mode_ff) begin
               if (iv_source_ff) begin
                  res_flags = gbmc_pkg::MODE_CBC_FLAG | gbmc_pkg::TABLE_FLAG;
                  res_idx   = iv_table_index_ff;
               end else begin
                  res_flags = gbmc_pkg::MODE_CBC_FLAG;
                  res_iv    = gbmc_pkg::gf2_mul(encrypt_matrix_ff, iv_value_ff);
               end
            end
         end
         if (enc_mode) begin
            enc_byte = gbmc_pkg::gf2_mul(encrypt_matrix_ff, in_data_ff ^ enc_chain);
            chain_in = enc_byte;
         end else begin
            enc_byte = gbmc_pkg::gf2_mul(encrypt_matrix_ff, in_data_ff);
            chain_in = enc_chain;
         end
         res_valid = 1'b1;
         res_byte  = enc_byte;
      end else if (!drop0) begin
         if (hc0 < gbmc_pkg::HDR_LEN) begin
            // Decrypt header: check and consume, no result unless it fails
            case (hc0)
               gbmc_pkg::POS_MAGIC0: begin
                  if (in_data_ff != gbmc_pkg::MAGIC0) res_status = gbmc_pkg::STATUS_BAD_MAGIC;
               end
               gbmc_pkg::POS_MAGIC1: begin
                  if (in_data_ff != gbmc_pkg::MAGIC1) res_status = gbmc_pkg::STATUS_BAD_MAGIC;
               end
               gbmc_pkg::POS_FLAGS: begin
                  if (hdr_mode > 7'd1) res_status = gbmc_pkg::STATUS_BAD_MODE;
                  mode_in  = hdr_mode[0];
                  tflag_in = in_data_ff[7];
               end
               gbmc_pkg::POS_IV: begin
                  chain_in = tflag_ff ? iv_value_ff : dec_byte;
               end
               default: ;
            endcase
            if (res_status != gbmc_pkg::STATUS_OK) begin
               dropped_in = 1'b1;
               res_valid  = 1'b1;
            end else begin
               hdr_cnt_in = hc0 + 4'd1;
            end
         end else begin
            res_valid = 1'b1;
            if (mode_ff) begin
               res_byte = dec_byte ^ chain0;
               chain_in = in_data_ff;
            end else begin
               res_byte = dec_byte;
            end
         end
      end
   end

   // Move the byte on when the slot is free or hands over its last result now
   assign slot_done  = slot_valid_ff && rsp_ch.ready && (slot_pos_ff == gbmc_pkg::DATA_POS);
   assign in_advance = in_valid_ff && (!slot_valid_ff || slot_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= '0;
         hdr_cnt_ff <= '0;
         mode_ff    <= 1'b0;
         tflag_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else if (in_advance) begin
         chain_ff   <= chain_in;
         hdr_cnt_ff <= hdr_cnt_in;
         mode_ff    <= mode_in;
         tflag_ff   <= tflag_in;
         dropped_ff <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         slot_pos_ff   <= '0;
      end else if (in_advance && res_valid) begin
         slot_valid_ff <= 1'b1;
         slot_pos_ff   <= res_header ? gbmc_pkg::POS_MAGIC0 : gbmc_pkg::DATA_POS;
      end else if (slot_done) begin
         slot_valid_ff <= 1'b0;
      end else if (slot_valid_ff && rsp_ch.ready) begin
         slot_pos_ff <= slot_pos_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance && res_valid) begin
         slot_flags_ff  <= res_flags;
         slot_iv_ff     <= res_iv;
         slot_idx_ff    <= res_idx;
         slot_byte_ff   <= res_byte;
         slot_status_ff <= res_status;
      end
   end

   // ---------------------------------------------------------------------------------
   // Output select: header bytes by position, index little-endian
   // ---------------------------------------------------------------------------------
   always_comb begin
      case (slot_pos_ff)
         gbmc_pkg::POS_MAGIC0:  rsp_ch.out_byte = gbmc_pkg::MAGIC0;
         gbmc_pkg::POS_MAGIC1:  rsp_ch.out_byte = gbmc_pkg::MAGIC1;
         gbmc_pkg::POS_FLAGS:   rsp_ch.out_byte = slot_flags_ff;
         gbmc_pkg::POS_IV:      rsp_ch.out_byte = slot_iv_ff;
         gbmc_pkg::POS_IDX0:    rsp_ch.out_byte = slot_idx_ff[7:0];
         gbmc_pkg::POS_IDX1:    rsp_ch.out_byte = slot_idx_ff[15:8];
         gbmc_pkg::POS_IDX2:    rsp_ch.out_byte = slot_idx_ff[23:16];
         gbmc_pkg::POS_IDX3:    rsp_ch.out_byte = slot_idx_ff[31:24];
         gbmc_pkg::POS_VERSION: rsp_ch.out_byte = gbmc_pkg::VERSION_BYTE;
         default:               rsp_ch.out_byte = slot_byte_ff;
      endcase
   end

   assign rsp_ch.valid       = slot_valid_ff;
   assign rsp_ch.is_header   = slot_pos_ff < gbmc_pkg::DATA_POS;
   assign rsp_ch.last_of_run = slot_pos_ff == gbmc_pkg::DATA_POS;
   assign rsp_ch.status      = rsp_ch.last_of_run ? slot_status_ff : gbmc_pkg::STATUS_OK;

endmodule

### verif/gbmc_stream_check.sv
// Stream checker for the byte matrix cipher: predicts each result and compares it.
module gbmc_stream_check (
   input  logic        clock,
   input  logic        reset,
   gbmc_req_if         req_mon,
   gbmc_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [63:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_count,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic [1:0] status;
      logic       last_of_run;
   } cipher_result_type;

   // Shadow copy of the register file
   logic        cfg_decrypt;
   logic        cfg_cbc;
   logic        cfg_table;
   logic [31:0] cfg_index;
   logic [7:0]  cfg_iv;
   logic [63:0] cfg_enc;
   logic [63:0] cfg_dec;

   // Per-message cipher state
   logic [7:0]  chain;
   logic [3:0]  hdr_count;
   logic        msg_cbc;
   logic        msg_table;
   logic        dropped;

   cipher_result_type cipher_results_q [$];
   int bad_results;
   int seen_results;

   // Sum the matrix columns picked by the set bits of v; column j holds bit j of every row
   function automatic logic [7:0] mat_vec(input logic [63:0] m, input logic [7:0] v);
      logic [7:0] acc;
      logic [7:0] col;
      acc = '0;
      for (int j = 0; j < gbmc_pkg::MatrixRows; j++) begin
         for (int i = 0; i < gbmc_pkg::MatrixRows; i++) begin
            col[gbmc_pkg::MatrixRows - 1 - i] = m[56 - 8 * i + j];
         end
         if (v[j]) acc ^= col;
      end
      return acc;
   endfunction

   function automatic cipher_result_type result_of(input logic [7:0] b, input logic hdr,
                                                   input logic [1:0] st);
      cipher_result_type r;
      r.out_byte = b;
      r.is_header = hdr;
      r.status = st;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic void predict_transaction(input logic [7:0] d, input logic som);
      cipher_result_type run [$];
      cipher_result_type tail;
      logic [7:0]  flags;
      logic [7:0]  iv_hdr;
      logic [7:0]  c;
      logic [31:0] idx;
      logic [1:0]  err;
      if (som) begin
         hdr_count = '0;
         dropped = 1'b0;
         chain = '0;
      end
      if (!cfg_decrypt) begin
         if (hdr_count < gbmc_pkg::HDR_LEN) begin
            msg_cbc = cfg_cbc;
            msg_table = cfg_table;
            chain = cfg_iv;
            flags = '0;
            iv_hdr = '0;
            idx = '0;
            if (msg_cbc) begin
               flags = gbmc_pkg::MODE_CBC_FLAG;
               if (msg_table) begin
                  flags |= gbmc_pkg::TABLE_FLAG;
                  idx = cfg_index;
               end else begin
                  iv_hdr = mat_vec(cfg_enc, cfg_iv);
               end
            end
            run.push_back(result_of(gbmc_pkg::MAGIC0, 1'b1, gbmc_pkg::STATUS_OK));
            run.push_back(result_of(gbmc_pkg::MAGIC1, 1'b1, gbmc_pkg::STATUS_OK));
            run.push_back(result_of(flags, 1'b1, gbmc_pkg::STATUS_OK));
            run.push_back(result_of(iv_hdr, 1'b1, gbmc_pkg::STATUS_OK));
            for (int i = 0; i < 4; i++) begin
               run.push_back(result_of(idx[8 * i +: 8], 1'b1, gbmc_pkg::STATUS_OK));
            end
            run.push_back(result_of(gbmc_pkg::VERSION_BYTE, 1'b1, gbmc_pkg::STATUS_OK));
            hdr_count = gbmc_pkg::HDR_LEN;
            dropped = 1'b0;
         end
         if (msg_cbc) begin
            c = mat_vec(cfg_enc, d ^ chain);
            chain = c;
         end else begin
            c = mat_vec(cfg_enc, d);
         end
         run.push_back(result_of(c, 1'b0, gbmc_pkg::STATUS_OK));
      end else if (!dropped) begin
         if (hdr_count < gbmc_pkg::HDR_LEN) begin
            err = gbmc_pkg::STATUS_OK;
            case (hdr_count)
               gbmc_pkg::POS_MAGIC0:
                  if (d != gbmc_pkg::MAGIC0) err = gbmc_pkg::STATUS_BAD_MAGIC;
               gbmc_pkg::POS_MAGIC1:
                  if (d != gbmc_pkg::MAGIC1) err = gbmc_pkg::STATUS_BAD_MAGIC;
               gbmc_pkg::POS_FLAGS: begin
                  if (d[6:0] > 7'd1) err = gbmc_pkg::STATUS_BAD_MODE;
                  msg_cbc = d[0];
                  msg_table = d[7];
               end
               gbmc_pkg::POS_IV: chain = msg_table ? cfg_iv : mat_vec(cfg_dec, d);
               default: ;
            endcase
            if (err != gbmc_pkg::STATUS_OK) begin
               dropped = 1'b1;
               run.push_back(result_of(8'h00, 1'b0, err));
            end else begin
               hdr_count = hdr_count + 4'd1;
            end
         end else begin
            c = mat_vec(cfg_dec, d);
            if (msg_cbc) begin
               c ^= chain;
               chain = d;
            end
            run.push_back(result_of(c, 1'b0, gbmc_pkg::STATUS_OK));
         end
      end
      if (run.size() > 0) begin
         tail = run.pop_back();
         tail.last_of_run = 1'b1;
         run.push_back(tail);
      end
      foreach (run[k]) cipher_results_q.push_back(run[k]);
   endfunction

   always @(posedge clock) begin
      cipher_result_type got;
      cipher_result_type want;
      if (reset) begin
         cfg_decrypt = 1'b0;
         cfg_cbc = 1'b0;
         cfg_table = 1'b0;
         cfg_index = '0;
         cfg_iv = '0;
         cfg_enc = '0;
         cfg_dec = '0;
         chain = '0;
         hdr_count = '0;
         msg_cbc = 1'b0;
         msg_table = 1'b0;
         dropped = 1'b0;
         cipher_results_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               gbmc_pkg::CSR_DIRECTION:      cfg_decrypt = csr_wdata[0];
               gbmc_pkg::CSR_CHAIN_MODE:     cfg_cbc = csr_wdata[0];
               gbmc_pkg::CSR_IV_SOURCE:      cfg_table = csr_wdata[0];
               gbmc_pkg::CSR_IV_TABLE_INDEX: cfg_index = csr_wdata[31:0];
               gbmc_pkg::CSR_IV_VALUE:       cfg_iv = csr_wdata[7:0];
               gbmc_pkg::CSR_ENCRYPT_MATRIX: cfg_enc = csr_wdata;
               gbmc_pkg::CSR_DECRYPT_MATRIX: cfg_dec = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.out_byte = rsp_mon.out_byte;
            got.is_header = rsp_mon.is_header;
            got.status = rsp_mon.status;
            got.last_of_run = rsp_mon.last_of_run;
            seen_results++;
            if (cipher_results_q.size() == 0) begin
               bad_results++;
               $display({"%0t: unexpected result, expected none,",
                         " got byte %02h hdr %0b st %0d last %0b"},
                        $time, got.out_byte, got.is_header, got.status, got.last_of_run);
            end else begin
               want = cipher_results_q.pop_front();
               if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
                   got.status !== want.status || got.last_of_run !== want.last_of_run) begin
                  bad_results++;
                  $display({"%0t: result mismatch, expected byte %02h hdr %0b st %0d last %0b,",
                            " got byte %02h hdr %0b st %0d last %0b"},
                           $time, want.out_byte, want.is_header, want.status,
                           want.last_of_run, got.out_byte, got.is_header, got.status,
                           got.last_of_run);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_transaction(req_mon.data_byte, req_mon.start_of_message);
      end
      mismatch_count <= bad_results;
      pending_count <= cipher_results_q.size();
      results_checked <= seen_results;
   end

endmodule

### verif/tb_gf2_byte_matrix_cipher_cbc_top.sv
// Testbench top: clock, reset, register setup, byte stimulus, idling phases and verdict.
module tb_gf2_byte_matrix_cipher_cbc_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 2000;
   localparam int SettleCycles = 6;
   localparam int RandomItems = 160;
   localparam int SegmentItems = 25;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam logic [63:0] MATRIX_IDENTITY = 64'h8040_2010_0804_0201;
   localparam logic [63:0] MATRIX_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum int {SHAPE_CLEAN, SHAPE_TRUNCATED, SHAPE_BROKEN} msg_shape_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [63:0] csr_wdata;

   gbmc_req_if req_ch();
   gbmc_rsp_if rsp_ch();

   int mismatches;
   int pending;
   int checked;
   int send_idle_pct;
   int rsp_stall_pct;
   int items_sent;
   int starts_sent;
   int random_items;
   int directed_items;
   int watchdog;
   logic cur_decrypt;

   always #2 clock = ~clock;

   gf2_byte_matrix_cipher_cbc_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   gbmc_stream_check stream_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_count  (pending),
      .results_checked(checked)
   );

   // Receiver: drop ready on a random share of cycles set by the current phase
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: count cycles in which neither channel moves a transaction
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         watchdog <= 0;
      end else if (watchdog >= WatchdogLimit) begin
         $display("watchdog expired at %0t with %0d results outstanding", $time, pending);
         $display("end of test: mismatches");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

   function automatic logic [63:0] random_u64();
      return {$urandom, $urandom};
   endfunction

   // Place a narrow register value under random upper bits of the write bus
   function automatic logic [63:0] over_noise(input logic [63:0] v, input int width);
      return (random_u64() << width) | v;
   endfunction

   function automatic logic [63:0] pick_matrix();
      case ($urandom_range(5))
         0: return 64'h0;
         1: return MATRIX_ONES;
         2: return MATRIX_IDENTITY;
         default: return random_u64();
      endcase
   endfunction

   // Offer one byte; hold it until the block takes it
   task automatic send_byte(input logic [7:0] d, input logic som);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= d;
      req_ch.start_of_message <= som;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (som) starts_sent++;
   endtask

   // Hold the sender until every expected result has come, then let the pipe empty
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] addr, input logic [63:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program the whole register file; the block must be idle
   task automatic apply_settings(input logic dir, input logic cbc, input logic tbl,
                                 input logic [31:0] idx, input logic [7:0] iv,
                                 input logic [63:0] enc, input logic [63:0] dec);
      write_reg(gbmc_pkg::CSR_DIRECTION, over_noise(64'(dir), 1));
      write_reg(gbmc_pkg::CSR_CHAIN_MODE, over_noise(64'(cbc), 1));
      write_reg(gbmc_pkg::CSR_IV_SOURCE, over_noise(64'(tbl), 1));
      write_reg(gbmc_pkg::CSR_IV_TABLE_INDEX, over_noise(64'(idx), 32));
      write_reg(gbmc_pkg::CSR_IV_VALUE, over_noise(64'(iv), 8));
      write_reg(gbmc_pkg::CSR_ENCRYPT_MATRIX, enc);
      write_reg(gbmc_pkg::CSR_DECRYPT_MATRIX, dec);
      // an index past the register file must be ignored
      write_reg(CSR_UNUSED, random_u64());
      csr_we <= 1'b0;
      @(posedge clock);
      cur_decrypt = dir;
   endtask

   task automatic random_settings();
      logic [31:0] idx;
      logic [7:0]  iv;
      case ($urandom_range(2))
         0: idx = '0;
         1: idx = '1;
         default: idx = $urandom;
      endcase
      case ($urandom_range(2))
         0: iv = '0;
         1: iv = '1;
         default: iv = 8'($urandom);
      endcase
      apply_settings(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                     idx, iv, pick_matrix(), pick_matrix());
   endtask

   // Plaintext message: random bytes, with a rare restart in the middle
   task automatic plain_message(input logic som);
      int n;
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
         send_byte(8'($urandom), (i == 0) ? som : ($urandom_range(15) == 0));
         random_items++;
      end
   endtask

   // Encrypted message as the decrypt side expects it: header then ciphertext
   task automatic cipher_message(input msg_shape_type shape, input logic som);
      logic [7:0]  hdr [gbmc_pkg::HeaderBytes];
      logic [31:0] idx;
      int last_pos;
      int n_data;
      idx = ($urandom_range(3) == 0) ? '1 : $urandom;
      hdr[gbmc_pkg::POS_MAGIC0] = gbmc_pkg::MAGIC0;
      hdr[gbmc_pkg::POS_MAGIC1] = gbmc_pkg::MAGIC1;
      case ($urandom_range(3))
         0: hdr[gbmc_pkg::POS_FLAGS] = 8'h00;
         1: hdr[gbmc_pkg::POS_FLAGS] = gbmc_pkg::MODE_CBC_FLAG;
         2: hdr[gbmc_pkg::POS_FLAGS] = gbmc_pkg::TABLE_FLAG;
         default: hdr[gbmc_pkg::POS_FLAGS] = gbmc_pkg::TABLE_FLAG | gbmc_pkg::MODE_CBC_FLAG;
      endcase
      hdr[gbmc_pkg::POS_IV] = 8'($urandom);
      hdr[gbmc_pkg::POS_IDX0] = idx[7:0];
      hdr[gbmc_pkg::POS_IDX1] = idx[15:8];
      hdr[gbmc_pkg::POS_IDX2] = idx[23:16];
      hdr[gbmc_pkg::POS_IDX3] = idx[31:24];
      hdr[gbmc_pkg::POS_VERSION] = ($urandom_range(3) == 0) ? 8'($urandom)
                                                             : gbmc_pkg::VERSION_BYTE;
      last_pos = gbmc_pkg::HeaderBytes - 1;
      n_data = $urandom_range(6);
      case (shape)
         SHAPE_TRUNCATED: begin
            last_pos = $urandom_range(gbmc_pkg::HeaderBytes - 2);
            n_data = 0;
         end
         SHAPE_BROKEN: begin
            // corrupt a magic byte or the mode bits, then trail bytes that get dropped
            last_pos = $urandom_range(2);
            case (4'(last_pos))
               gbmc_pkg::POS_MAGIC0:
                  hdr[gbmc_pkg::POS_MAGIC0] = gbmc_pkg::MAGIC0 ^ 8'($urandom_range(255, 1));
               gbmc_pkg::POS_MAGIC1:
                  hdr[gbmc_pkg::POS_MAGIC1] = gbmc_pkg::MAGIC1 ^ 8'($urandom_range(255, 1));
               default:
                  hdr[gbmc_pkg::POS_FLAGS] = {1'($urandom), 7'($urandom_range(127, 2))};
            endcase
         end
         default: ;
      endcase
      for (int i = 0; i <= last_pos; i++) begin
         send_byte(hdr[i], (i == 0) ? som : 1'b0);
         random_items++;
      end
      repeat (n_data) begin
         send_byte(8'($urandom), 1'b0);
         if (shape != SHAPE_BROKEN) random_items++;
      end
   endtask

   // Junk bytes with random start markers
   task automatic noise_burst();
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom), 1'($urandom_range(1)));
   endtask

   initial begin
      int seg;
      int seg_base;
      int pick;
      logic first;
      logic som;

      req_ch.valid = 1'b0;
      req_ch.data_byte = '0;
      req_ch.start_of_message = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      cur_decrypt = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Reset registers: encrypt, ECB, zero matrix
      send_byte(8'hFF, 1'b1);
      drain();

      // CBC with stored IV, all-ones key, extreme IV and index
      apply_settings(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 8'hFF, MATRIX_ONES, MATRIX_IDENTITY);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      drain();

      // CBC with table IV: index lands in the header
      apply_settings(1'b0, 1'b1, 1'b1, 32'hA5C3_0F81, 8'h00, MATRIX_IDENTITY, MATRIX_ONES);
      send_byte(8'h5A, 1'b1);
      send_byte(8'hA5, 1'b0);
      drain();

      // Flip to decrypt in the middle of that message: the chain carries over
      apply_settings(1'b1, 1'b0, 1'b0, 32'h0, 8'h00, MATRIX_ONES, MATRIX_IDENTITY);
      send_byte(8'h3C, 1'b0);

      // Full stored-IV CBC header, unchecked version byte, then one ciphertext byte
      send_byte(gbmc_pkg::MAGIC0, 1'b1);
      send_byte(gbmc_pkg::MAGIC1, 1'b0);
      send_byte(gbmc_pkg::MODE_CBC_FLAG, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'hFF, 1'b0);

      // Bad first magic, then a byte of the dropped message
      send_byte(8'h00, 1'b1);
      send_byte(gbmc_pkg::MAGIC0, 1'b0);
      // Bad second magic
      send_byte(gbmc_pkg::MAGIC0, 1'b1);
      send_byte(8'hFF, 1'b0);
      // Unsupported mode bits
      send_byte(gbmc_pkg::MAGIC0, 1'b1);
      send_byte(gbmc_pkg::MAGIC1, 1'b0);
      send_byte(8'h7E, 1'b0);
      directed_items = items_sent;

      // Random part: segments with fresh settings and their own idling phase
      seg = 0;
      while (random_items < RandomItems) begin
         drain();
         random_settings();
         case (seg % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 72; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 72; end
            default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
         endcase
         seg_base = random_items;
         first = 1'b1;
         while (random_items - seg_base < SegmentItems) begin
            // sometimes continue the previous message across the settings change
            som = first ? ($urandom_range(3) != 0) : 1'b1;
            pick = $urandom_range(99);
            if (!cur_decrypt) begin
               if (pick < 90) plain_message(som);
               else noise_burst();
            end else begin
               if (pick < 70) cipher_message(SHAPE_CLEAN, som);
               else if (pick < 80) cipher_message(SHAPE_TRUNCATED, som);
               else if (pick < 92) cipher_message(SHAPE_BROKEN, som);
               else noise_burst();
            end
            // pause the sender once per segment until the results catch up
            if (first) drain();
            first = 1'b0;
         end
         seg++;
      end

      // Stop offering bytes and wait for the last results
      drain();
      $display("Sent %0d request transactions (%0d directed, %0d message starts)",
               items_sent, directed_items, starts_sent);
      $display("Checked %0d results over %0d segments: encrypt, decrypt, ECB, CBC, stalls",
               checked, seg);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
